>>> rtl/core/mwtd_pkg.sv
package mwtd_pkg;

    localparam int WINDOW      = 11;
    localparam int MID         = WINDOW / 2;
    localparam int SAMPLE_W    = 8;
    localparam int CNT_W       = $clog2(WINDOW);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 8'd25;
    localparam logic [CNT_W-1:0]    CNT_LAST     = CNT_W'(WINDOW - 1);

    // register index decoded from paddr[2]
    localparam logic REG_DETECT_THRESHOLD = 1'b0;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // one sorting cell: an empty cell acts as +infinity
    typedef struct packed {
        logic    valid;
        sample_t value;
    } cell_t;

endpackage

>>> rtl/core/mwtd_if.sv
interface mwtd_sample_if;
    logic                valid;
    logic                ready;
    mwtd_pkg::sample_t   distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

interface mwtd_result_if;
    logic                valid;
    logic                ready;
    mwtd_pkg::sample_t   median_distance;
    logic                object_found;

    modport source (output valid, output median_distance, output object_found, input ready);
    modport sink   (input valid, input median_distance, input object_found, output ready);
endinterface

>>> rtl/core/mwtd_cell.sv
module mwtd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ins,
    input  logic                clear,
    input  mwtd_pkg::sample_t   sample,
    input  mwtd_pkg::cell_t     left,
    output mwtd_pkg::cell_t     cur,
    output mwtd_pkg::cell_t     nxt
);

    logic              valid_reg;
    logic              valid_next;
    mwtd_pkg::sample_t value_reg;
    mwtd_pkg::sample_t value_next;
    logic              own_gt;
    logic              left_gt;

    assign cur.valid = valid_reg;
    assign cur.value = value_reg;

    // greater than the new sample; empty counts as greater
    assign own_gt  = !valid_reg || (value_reg > sample);
    assign left_gt = !left.valid || (left.value > sample);

    always_comb
    begin
        nxt.valid = valid_reg;
        nxt.value = value_reg;
        if (own_gt)
        begin
            if (left_gt)
            begin
                nxt = left;
            end
            else
            begin
                nxt.valid = 1'b1;
                nxt.value = sample;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ins)
        begin
            valid_next = nxt.valid && !clear;
            value_next = nxt.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> rtl/core/median_of_window_threshold_detect.sv
// Batch median detector for a stream of 8-bit distance samples.
// Samples arrive on the sample channel (valid/ready), one per request.
// They are gathered in non-overlapping batches of WINDOW samples and kept
// sorted by a row of WINDOW insertion cells; each accepted sample is placed
// in order in the same cycle, so one sample is taken per clock while ready.
// When the last sample of a batch is accepted, the middle cell is loaded
// into the result register at that edge; the result request (median and
// object_found = median < threshold) is valid from the next cycle.
// Throughput: 1 sample per cycle while sample ready is high; the cell row
// and the batch count are the only state of a batch.
// The threshold register is at APB addresses 0-3 (reset 25); writes elsewhere
// are ignored. It should only be written while no batch is in progress.
// Reset empties the row and the result register and zeroes the batch count.
// If the receiver stalls with a result pending, sample ready drops until the
// result is taken, so no sample and no result is lost.
module median_of_window_threshold_detect (
    input  logic                        clk,
    input  logic                        rst_n,
    mwtd_sample_if.sink                 samples,
    mwtd_result_if.source               results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwtd_pkg::ADDR_W-1:0] paddr,
    input  logic [mwtd_pkg::DATA_W-1:0] pwdata,
    output logic [mwtd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    mwtd_pkg::cell_t                 chain [mwtd_pkg::WINDOW+1];
    mwtd_pkg::cell_t                 chain_nxt [mwtd_pkg::WINDOW];
    logic [mwtd_pkg::WINDOW-1:0]     valid_vec;

    mwtd_pkg::sample_t               thresh_reg;
    mwtd_pkg::sample_t               thresh_next;
    logic [mwtd_pkg::CNT_W-1:0]      count_reg;
    logic [mwtd_pkg::CNT_W-1:0]      count_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    mwtd_pkg::sample_t               median_reg;
    mwtd_pkg::sample_t               median_next;
    logic                            found_reg;
    logic                            found_next;

    logic                            accept;
    logic                            batch_end;
    logic                            cfg_write;
    logic                            sorted_ok;

    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign batch_end     = accept && (count_reg == mwtd_pkg::CNT_LAST);

    // the head cell sees a left neighbor that never exceeds a sample
    assign chain[0].valid = 1'b1;
    assign chain[0].value = '0;

    for (genvar i = 0; i < mwtd_pkg::WINDOW; i++)
    begin : g_cell
        mwtd_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ins    (accept),
            .clear  (batch_end),
            .sample (samples.distance),
            .left   (chain[i]),
            .cur    (chain[i+1]),
            .nxt    (chain_nxt[i])
        );
        assign valid_vec[i] = chain[i+1].valid;
    end

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == mwtd_pkg::REG_DETECT_THRESHOLD);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mwtd_pkg::REG_DETECT_THRESHOLD)
        begin
            prdata = mwtd_pkg::DATA_W'(thresh_reg);
        end
    end

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_write)
        begin
            thresh_next = pwdata[mwtd_pkg::SAMPLE_W-1:0];
        end
    end

    // batch count and result register
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        found_next     = found_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            count_next = count_reg + 1'b1;
        end
        if (batch_end)
        begin
            count_next     = '0;
            out_valid_next = 1'b1;
            median_next    = chain_nxt[mwtd_pkg::MID].value;
            found_next     = chain_nxt[mwtd_pkg::MID].value < thresh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= mwtd_pkg::THRESH_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thresh_reg    <= thresh_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
        found_reg  <= found_next;
    end

    assign results.valid           = out_valid_reg;
    assign results.median_distance = median_reg;
    assign results.object_found    = found_reg;

    // filled cells stay ascending
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < mwtd_pkg::WINDOW; i++)
        begin
            if (chain[i+1].valid && chain[i].valid && (chain[i].value > chain[i+1].value))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
        else $error("cell row out of order");

    a_fill_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("filled cells disagree with batch count");

    a_result_from_batch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(batch_end))
        else $error("result without a completed batch");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> (out_valid_reg && $stable(median_reg)))
        else $error("pending result lost");

endmodule
